// ===== hdl/atle_pkg.sv =====
`default_nettype none

package atle_pkg;

    // Longest line the editor keeps.
    localparam int LINE_LEN_DEF = 64;

    // Width of the cursor and length fields.
    localparam int POS_W = 7;

    // Result kinds.
    localparam logic [1:0] KIND_EDIT  = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    // Commands from the parser to the line engine.
    typedef enum logic [3:0] {
        OP_STATUS,
        OP_LEFT,
        OP_RIGHT,
        OP_ERASE,
        OP_CLEAR,
        OP_CR,
        OP_LF,
        OP_BS,
        OP_INSERT
    } t_op;

    // The argument is the escape count for cursor moves and the byte for an insert.
    typedef struct packed {
        t_op        op;
        logic [7:0] arg;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       char_out;
        logic             last;
        logic [POS_W-1:0] cursor;
        logic [POS_W-1:0] length;
        logic             overflow;
    } t_res;

endpackage

`default_nettype wire

// ===== hdl/atle_fifo.sv =====
`default_nettype none

module atle_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/atle_front.sv =====
`default_nettype none

module atle_front (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_accept,
    input  wire logic [7:0] i_char,
    output atle_pkg::t_cmd  o_cmd
);

    localparam logic [7:0] CH_ESC     = 8'd27;
    localparam logic [7:0] CH_BRACKET = 8'h5B;
    localparam logic [7:0] CH_BS      = 8'd8;
    localparam logic [7:0] CH_DEL     = 8'd127;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_D       = 8'h44;
    localparam logic [7:0] CH_C       = 8'h43;
    localparam logic [7:0] CH_K       = 8'h4B;
    localparam logic [7:0] CH_J       = 8'h4A;
    localparam logic [7:0] CLEAR_ARG  = 8'd2;

    typedef enum logic [1:0] {
        PS_IDLE,
        PS_ESC,
        PS_BRK
    } t_pstate;

    t_pstate     r_ps;
    t_pstate     n_ps;
    logic [7:0]  r_count;
    logic [7:0]  n_count;
    logic [11:0] acc;

    // A byte outside an escape sequence.
    function automatic atle_pkg::t_cmd plain_cmd(input logic [7:0] c);
        atle_pkg::t_cmd cmd;
        cmd.arg = c;
        if (c == CH_CR) begin
            cmd.op = atle_pkg::OP_CR;
        end else if (c == CH_LF) begin
            cmd.op = atle_pkg::OP_LF;
        end else if (c == CH_BS || c == CH_DEL) begin
            cmd.op = atle_pkg::OP_BS;
        end else begin
            cmd.op = atle_pkg::OP_INSERT;
        end
        return cmd;
    endfunction

    // Count times ten plus the new digit, saturated below.
    assign acc = {1'b0, r_count, 3'b000} + {3'b000, r_count, 1'b0}
               + {8'd0, 4'(i_char - CH_0)};

    always_comb begin
        n_ps      = PS_IDLE;
        n_count   = r_count;
        o_cmd.op  = atle_pkg::OP_STATUS;
        o_cmd.arg = r_count;
        unique case (r_ps)
            PS_ESC: begin
                if (i_char == CH_BRACKET) begin
                    n_ps = PS_BRK;
                end else begin
                    o_cmd = plain_cmd(i_char);
                end
            end
            PS_BRK: begin
                if (i_char >= CH_0 && i_char <= CH_9) begin
                    n_ps    = PS_BRK;
                    n_count = (acc > 12'd255) ? 8'hFF : acc[7:0];
                end else if (i_char == CH_D) begin
                    o_cmd.op = atle_pkg::OP_LEFT;
                end else if (i_char == CH_C) begin
                    o_cmd.op = atle_pkg::OP_RIGHT;
                end else if (i_char == CH_K) begin
                    o_cmd.op = atle_pkg::OP_ERASE;
                end else if (i_char == CH_J && r_count == CLEAR_ARG) begin
                    o_cmd.op = atle_pkg::OP_CLEAR;
                end
            end
            default: begin
                if (i_char == CH_ESC) begin
                    n_ps    = PS_ESC;
                    n_count = 8'd0;
                end else begin
                    o_cmd = plain_cmd(i_char);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps    <= PS_IDLE;
            r_count <= 8'd0;
        end else if (i_accept) begin
            r_ps    <= n_ps;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/atle_back.sv =====
`default_nettype none

module atle_back #(
    parameter int LINE_LEN = atle_pkg::LINE_LEN_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire atle_pkg::t_cmd i_cmd,
    input  wire logic           i_cmd_empty,
    output logic                o_cmd_pop,
    output atle_pkg::t_res      o_res,
    output logic                o_res_push,
    input  wire logic           i_res_full
);

    localparam int IW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
    localparam logic [atle_pkg::POS_W-1:0] LEN_MAX = atle_pkg::POS_W'(LINE_LEN);
    localparam logic [atle_pkg::POS_W-1:0] POS_ONE = atle_pkg::POS_W'(1);
    localparam logic [atle_pkg::POS_W-1:0] POS_ZERO = '0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_SH_RD,
        S_SH_WR,
        S_INS_WR,
        S_LF_RD,
        S_LF_DATA
    } t_state;

    t_state                        r_state, n_state;
    logic [atle_pkg::POS_W-1:0]    r_cursor, n_cursor;
    logic [atle_pkg::POS_W-1:0]    r_length, n_length;
    logic [IW-1:0]                 r_idx, n_idx;
    logic [7:0]                    r_char, n_char;
    logic [1:0]                    r_kind, n_kind;
    logic                          r_ovf, n_ovf;

    logic [7:0]    r_mem [LINE_LEN];
    logic [7:0]    r_rdata;
    logic          we;
    logic [IW-1:0] wa;
    logic [7:0]    wd;
    logic [IW-1:0] ra;

    logic [atle_pkg::POS_W+1:0] right_sum;
    logic                       lf_last;

    assign right_sum = {2'b00, r_cursor} + {1'b0, i_cmd.arg};
    assign lf_last   = (atle_pkg::POS_W'(r_idx) + POS_ONE == r_length);

    always_comb begin
        n_state    = r_state;
        n_cursor   = r_cursor;
        n_length   = r_length;
        n_idx      = r_idx;
        n_char     = r_char;
        n_kind     = r_kind;
        n_ovf      = r_ovf;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        we         = 1'b0;
        wa         = r_idx;
        wd         = r_rdata;
        ra         = r_idx;

        o_res.kind     = r_kind;
        o_res.char_out = 8'd0;
        o_res.last     = 1'b1;
        o_res.cursor   = r_cursor;
        o_res.length   = r_length;
        o_res.overflow = r_ovf;

        unique case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_kind    = atle_pkg::KIND_EDIT;
                    n_ovf     = 1'b0;
                    n_state   = S_EMIT;
                    case (i_cmd.op)
                        atle_pkg::OP_LEFT: begin
                            n_cursor = ({1'b0, r_cursor} > i_cmd.arg)
                                     ? r_cursor - i_cmd.arg[atle_pkg::POS_W-1:0] : POS_ZERO;
                        end
                        atle_pkg::OP_RIGHT: begin
                            n_cursor = (right_sum > {2'b00, r_length})
                                     ? r_length : right_sum[atle_pkg::POS_W-1:0];
                        end
                        atle_pkg::OP_ERASE: begin
                            n_length = r_cursor;
                        end
                        atle_pkg::OP_CLEAR: begin
                            n_cursor = POS_ZERO;
                            n_length = POS_ZERO;
                            n_kind   = atle_pkg::KIND_CLEAR;
                        end
                        atle_pkg::OP_CR: begin
                            n_cursor = POS_ZERO;
                        end
                        atle_pkg::OP_BS: begin
                            n_length = (r_length != POS_ZERO) ? r_length - POS_ONE : POS_ZERO;
                            n_cursor = (r_cursor != POS_ZERO) ? r_cursor - POS_ONE : POS_ZERO;
                            if (n_cursor > n_length) begin
                                n_cursor = n_length;
                            end
                        end
                        atle_pkg::OP_INSERT: begin
                            n_char = i_cmd.arg;
                            if (r_length >= LEN_MAX) begin
                                n_ovf = 1'b1;
                            end else if (r_length == r_cursor) begin
                                we       = 1'b1;
                                wa       = IW'(r_cursor);
                                wd       = i_cmd.arg;
                                n_length = r_length + POS_ONE;
                                n_cursor = r_cursor + POS_ONE;
                            end else begin
                                n_idx   = IW'(r_length);
                                n_state = S_SH_RD;
                            end
                        end
                        atle_pkg::OP_LF: begin
                            if (r_length == POS_ZERO) begin
                                n_kind = atle_pkg::KIND_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_state = S_LF_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SH_RD: begin
                ra      = r_idx - IW'(1);
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                ra    = r_idx - IW'(1);
                we    = 1'b1;
                wa    = r_idx;
                wd    = r_rdata;
                n_idx = r_idx - IW'(1);
                n_state = (r_idx - IW'(1) == IW'(r_cursor)) ? S_INS_WR : S_SH_RD;
            end
            S_INS_WR: begin
                we       = 1'b1;
                wa       = IW'(r_cursor);
                wd       = r_char;
                n_length = r_length + POS_ONE;
                n_cursor = r_cursor + POS_ONE;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                o_res_push = 1'b1;
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            S_LF_RD: begin
                n_state = S_LF_DATA;
            end
            S_LF_DATA: begin
                o_res_push     = 1'b1;
                o_res.kind     = atle_pkg::KIND_LINE;
                o_res.char_out = r_rdata;
                o_res.last     = lf_last;
                o_res.cursor   = POS_ZERO;
                o_res.length   = POS_ZERO;
                o_res.overflow = 1'b0;
                if (!i_res_full) begin
                    if (lf_last) begin
                        n_cursor = POS_ZERO;
                        n_length = POS_ZERO;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_LF_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rdata <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cursor <= '0;
            r_length <= '0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_length <= n_length;
        end
        r_idx  <= n_idx;
        r_char <= n_char;
        r_kind <= n_kind;
        r_ovf  <= n_ovf;
    end

endmodule

`default_nettype wire

// ===== hdl/ansi_terminal_line_editor_unit.sv =====
// Channel   Direction  Handshake            Fields
// input     in         push / full          i_char_in
// result    out        pop / empty          o_kind, o_char_out, o_last, o_cursor,
//                                           o_length, o_overflow
//
// The front takes one byte in every cycle that the two-beat command queue has room.
// The engine applies an ordinary byte in its idle state, then emits its beat from the emit state.
// A mid-line insert shifts the tail one entry at a time through a read and a write state, then writes the byte.
// A line feed reads each committed character and emits it as a line beat, one after another.
// Reset (synchronous, active low) empties both queues and clears parser, cursor and length.
// A full result queue stalls the engine, and a full command queue then raises full.
`default_nettype none

module ansi_terminal_line_editor_unit #(
    parameter int LINE_LEN = atle_pkg::LINE_LEN_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_char_in,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_char_out,
    output logic             o_last,
    output logic [6:0]       o_cursor,
    output logic [6:0]       o_length,
    output logic             o_overflow
);

    atle_pkg::t_cmd front_cmd;
    atle_pkg::t_cmd head_cmd;
    logic           cmd_empty;
    logic           cmd_pop;
    logic           in_beat;

    atle_pkg::t_res back_res;
    atle_pkg::t_res out_res;
    logic           res_push;
    logic           res_full;

    // An input beat moves when the command queue has a free slot.
    assign in_beat = push && !full;

    // The parser turns every byte into exactly one command for the engine.
    atle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_beat),
        .i_char   (i_char_in),
        .o_cmd    (front_cmd)
    );

    atle_fifo #(
        .WIDTH ($bits(atle_pkg::t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_beat),
        .i_data  (front_cmd),
        .i_pop   (cmd_pop),
        .o_data  (head_cmd),
        .o_full  (full),
        .o_empty (cmd_empty)
    );

    // The engine owns the cursor, the length and the line memory.
    atle_back #(
        .LINE_LEN (LINE_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (back_res),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    // The result queue lets the engine move on while a finished beat waits.
    atle_fifo #(
        .WIDTH ($bits(atle_pkg::t_res))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign o_kind     = out_res.kind;
    assign o_char_out = out_res.char_out;
    assign o_last     = out_res.last;
    assign o_cursor   = out_res.cursor;
    assign o_length   = out_res.length;
    assign o_overflow = out_res.overflow;

    // The engine never takes a command from an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command taken from an empty queue");

    // The cursor never passes the end of the line.
    a_cursor_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_cursor <= o_length))
        else $error("cursor beyond line length");

    // The line never grows beyond its storage.
    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_length <= 7'(LINE_LEN)))
        else $error("line length beyond storage");

    // Only committed-line beats carry a character.
    a_char_only_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind != atle_pkg::KIND_LINE) |-> (o_char_out == 8'd0))
        else $error("character on a beat that is not a line character");

endmodule

`default_nettype wire

// ===== verif/ansi_terminal_line_editor_unit_tb.sv =====
module ansi_terminal_line_editor_unit_tb;

    // The run is bounded so that a hung handshake cannot stall it forever.
    localparam int CYCLE_LIMIT   = 5_000_000;
    // The longest insert shifts 63 entries, and this settle wait covers the tail.
    localparam int SETTLE_CYCLES = 200;
    // The receiver stops popping for this long while the line is being filled.
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 50;
    localparam int LINE_LEN      = atle_pkg::LINE_LEN_DEF;

    // Bytes that the editor treats as controls.
    localparam logic [7:0] BYTE_ESC      = 8'd27;
    localparam logic [7:0] BYTE_LBRACKET = "[";
    localparam logic [7:0] BYTE_BS       = 8'd8;
    localparam logic [7:0] BYTE_DEL      = 8'd127;
    localparam logic [7:0] BYTE_CR       = 8'd13;
    localparam logic [7:0] BYTE_LF       = 8'd10;
    localparam logic [7:0] BYTE_ZERO     = "0";
    localparam logic [7:0] BYTE_NINE     = "9";

    // Final bytes of a control sequence.
    localparam logic [7:0] FINAL_LEFT  = "D";
    localparam logic [7:0] FINAL_RIGHT = "C";
    localparam logic [7:0] FINAL_ERASE = "K";
    localparam logic [7:0] FINAL_CLEAR = "J";
    localparam int         CLEAR_COUNT = 2;
    localparam int         COUNT_MAX   = 255;

    typedef enum logic [1:0] {
        PARSE_IDLE,
        PARSE_ESC,
        PARSE_CSI
    } t_parse;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_char_in;
    logic       empty;
    logic       pop;
    logic [1:0] o_kind;
    logic [7:0] o_char_out;
    logic       o_last;
    logic [6:0] o_cursor;
    logic [6:0] o_length;
    logic       o_overflow;

    ansi_terminal_line_editor_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_char_in  (i_char_in),
        .empty      (empty),
        .pop        (pop),
        .o_kind     (o_kind),
        .o_char_out (o_char_out),
        .o_last     (o_last),
        .o_cursor   (o_cursor),
        .o_length   (o_length),
        .o_overflow (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the editor: escape parser, cursor, length and line contents.
    t_parse     csi_state   = PARSE_IDLE;
    int         csi_count   = 0;
    int         edit_cursor = 0;
    int         edit_length = 0;
    logic [7:0] line_buf [LINE_LEN];

    // Result beats that the editor still owes us, oldest first.
    atle_pkg::t_res pending_results [$];

    int  bytes_sent    = 0;
    int  fail_count    = 0;
    int  cycle_count   = 0;
    // When set, both sides run back to back with no idle cycles.
    bit  no_gaps       = 1'b0;
    // A test raises this to ask the receiver for a long hold-off.
    bit  hold_req      = 1'b0;
    int  hold_left     = 0;
    int  pop_stall     = 0;

    // Most gaps are short, a few are long enough to drain or fill the queues.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic void queue_result(input logic [1:0] kind, input logic [7:0] ch,
                                         input logic last, input logic ovf);
        atle_pkg::t_res r;
        r.kind     = kind;
        r.char_out = ch;
        r.last     = last;
        r.cursor   = atle_pkg::POS_W'(edit_cursor);
        r.length   = atle_pkg::POS_W'(edit_length);
        r.overflow = ovf;
        pending_results = {pending_results, r};
    endfunction

    // Applies one accepted byte to the shadow editor and queues the beats it causes.
    function automatic void apply_byte(input logic [7:0] c);
        bit         consumed;
        logic [1:0] kind;
        logic       ovf;
        int         v;
        int         n;
        consumed = 1'b0;
        kind     = atle_pkg::KIND_EDIT;
        ovf      = 1'b0;

        case (csi_state)
            PARSE_ESC: begin
                // Anything but a bracket cancels the escape and is handled as plain text.
                if (c == BYTE_LBRACKET) begin
                    csi_state = PARSE_CSI;
                    consumed  = 1'b1;
                end else begin
                    csi_state = PARSE_IDLE;
                end
            end
            PARSE_CSI: begin
                consumed = 1'b1;
                if (c >= BYTE_ZERO && c <= BYTE_NINE) begin
                    v = csi_count * 10 + int'(c - BYTE_ZERO);
                    csi_count = (v > COUNT_MAX) ? COUNT_MAX : v;
                end else begin
                    if (c == FINAL_LEFT) begin
                        edit_cursor = (edit_cursor > csi_count) ? edit_cursor - csi_count : 0;
                    end else if (c == FINAL_RIGHT) begin
                        v = edit_cursor + csi_count;
                        edit_cursor = (v > edit_length) ? edit_length : v;
                    end else if (c == FINAL_ERASE) begin
                        edit_length = edit_cursor;
                    end else if (c == FINAL_CLEAR && csi_count == CLEAR_COUNT) begin
                        edit_length = 0;
                        edit_cursor = 0;
                        kind = atle_pkg::KIND_CLEAR;
                    end
                    // Unknown finals are swallowed without any effect.
                    csi_state = PARSE_IDLE;
                end
            end
            default: begin
                csi_state = PARSE_IDLE;
                if (c == BYTE_ESC) begin
                    csi_state = PARSE_ESC;
                    csi_count = 0;
                    consumed  = 1'b1;
                end
            end
        endcase

        if (consumed) begin
            queue_result(kind, 8'h00, 1'b1, 1'b0);
        end else if (c == BYTE_LF) begin
            // The commit reports the fresh empty line in every beat.
            n = edit_length;
            edit_length = 0;
            edit_cursor = 0;
            if (n == 0) begin
                queue_result(atle_pkg::KIND_EMPTY, 8'h00, 1'b1, 1'b0);
            end else begin
                for (int i = 0; i < n; i++) begin
                    queue_result(atle_pkg::KIND_LINE, line_buf[i], (i == n - 1), 1'b0);
                end
            end
        end else begin
            if (c == BYTE_CR) begin
                edit_cursor = 0;
            end else if (c == BYTE_BS || c == BYTE_DEL) begin
                // Rubout always drops the last character, wherever the cursor stands.
                if (edit_length > 0) edit_length--;
                if (edit_cursor > 0) edit_cursor--;
                if (edit_cursor > edit_length) edit_cursor = edit_length;
            end else if (edit_length >= LINE_LEN) begin
                ovf = 1'b1;
            end else begin
                if (edit_cursor > edit_length) edit_cursor = edit_length;
                for (int i = edit_length; i > edit_cursor; i--) begin
                    line_buf[i] = line_buf[i - 1];
                end
                line_buf[edit_cursor] = c;
                edit_length++;
                edit_cursor++;
            end
            queue_result(atle_pkg::KIND_EDIT, 8'h00, 1'b1, ovf);
        end
    endfunction

    // Offers one byte, waits for the input beat, then idles for a random gap.
    // When the gap is zero, push stays high for the next call.
    task automatic send_byte(input logic [7:0] c);
        int gap;
        @(negedge i_clk);
        push      <= 1'b1;
        i_char_in <= c;
        do @(posedge i_clk); while (full);
        apply_byte(c);
        bytes_sent++;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Sends ESC [ followed by the count digits and the final byte.
    task automatic send_csi(input string digits, input logic [7:0] fin);
        send_byte(BYTE_ESC);
        send_byte(BYTE_LBRACKET);
        send_text(digits);
        send_byte(fin);
    endtask

    task automatic release_input();
        if (push) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
    endtask

    // The sender stops until every owed beat has come back, then lets the engine settle.
    task automatic wait_for_results();
        release_input();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Commit of an empty line, then the two extreme byte values go into the line.
    task automatic test_commit();
        send_byte(BYTE_LF);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    // Insert at column zero, clamped right move, saturating left move, rubout at
    // column zero and erase to end of line.
    task automatic test_cursor_moves();
        send_byte(BYTE_CR);
        send_byte("Z");
        send_csi("9", FINAL_RIGHT);
        send_csi("999", FINAL_LEFT);
        send_byte(BYTE_BS);
        send_csi("", FINAL_ERASE);
    endtask

    // An escape followed by another escape puts one escape into the line, which is then
    // committed. A clear with the wrong count is ignored, and rubout on an empty line
    // leaves the cursor at zero.
    task automatic test_escape_oddities();
        send_byte(BYTE_ESC);
        send_byte(BYTE_ESC);
        send_byte(BYTE_LF);
        send_csi("7", FINAL_CLEAR);
        send_byte(BYTE_DEL);
    endtask

    // The receiver holds off while the line is filled past its end, so both queues back
    // up and full is raised. Then come a dropped byte, mid-line and front inserts into a
    // nearly full line, and a full-length commit. The sender then waits for all beats.
    task automatic test_full_line_stall();
        send_csi("2", FINAL_CLEAR);
        hold_req = 1'b1;
        repeat (LINE_LEN + 3) send_byte(8'($urandom_range(32, 126)));
        send_csi("20", FINAL_LEFT);
        send_byte("Q");
        send_byte(BYTE_BS);
        send_byte("Q");
        send_byte(BYTE_CR);
        send_byte(BYTE_DEL);
        send_byte("A");
        send_byte(BYTE_LF);
        wait_for_results();
    endtask

    // Mostly well-formed text and control sequences with random content, plus noise
    // bytes and broken sequences. The first stretch runs without any idle cycles.
    task automatic test_random_traffic();
        int    start;
        int    r;
        string digits;
        logic [7:0] fin;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_ITEMS) begin
            no_gaps = (bytes_sent - start < 20);
            r = $urandom_range(0, 99);
            if (r < 40) begin
                send_byte(8'($urandom_range(32, 126)));
            end else if (r < 48) begin
                send_byte(8'($urandom_range(0, 255)));
            end else if (r < 66) begin
                case ($urandom_range(0, 3))
                    0:       fin = FINAL_LEFT;
                    1:       fin = FINAL_RIGHT;
                    2:       fin = FINAL_ERASE;
                    default: fin = FINAL_CLEAR;
                endcase
                if ($urandom_range(0, 3) == 0) begin
                    digits = "";
                end else if ($urandom_range(0, 4) == 0) begin
                    digits = $sformatf("%0d", $urandom_range(0, 999));
                end else begin
                    digits = $sformatf("%0d", $urandom_range(0, 12));
                end
                if (fin == FINAL_CLEAR && $urandom_range(0, 1) == 1) digits = "2";
                send_csi(digits, fin);
            end else if (r < 72) begin
                // Broken sequence: a random byte where the bracket or the final belongs.
                send_byte(BYTE_ESC);
                if ($urandom_range(0, 1) == 1) send_byte(BYTE_LBRACKET);
                send_byte(8'($urandom_range(0, 255)));
            end else if (r < 80) begin
                send_byte(BYTE_CR);
            end else if (r < 88) begin
                send_byte($urandom_range(0, 1) ? BYTE_BS : BYTE_DEL);
            end else if (r < 94) begin
                send_byte(BYTE_LF);
            end else begin
                // A burst of text pushes lines toward their full length.
                repeat ($urandom_range(5, 20)) send_byte(8'($urandom_range(32, 126)));
            end
        end
        no_gaps = 1'b0;
    endtask

    // Receiver: random stalls, a long hold-off on request, none while no_gaps is set.
    initial begin
        int gap;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else if (pop_stall > 0) begin
                pop <= 1'b0;
                pop_stall--;
            end else if (no_gaps) begin
                pop <= 1'b1;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    pop <= 1'b1;
                end else begin
                    pop <= 1'b0;
                    pop_stall = gap - 1;
                end
            end
        end
    end

    // Every result beat is matched against the oldest owed beat.
    always @(posedge i_clk) begin
        atle_pkg::t_res got;
        atle_pkg::t_res want;
        if (i_rst_n && pop && !empty) begin
            got.kind     = o_kind;
            got.char_out = o_char_out;
            got.last     = o_last;
            got.cursor   = o_cursor;
            got.length   = o_length;
            got.overflow = o_overflow;
            if (pending_results.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected beat: kind=%0d char=%02h last=%0d cur=%0d len=%0d",
                             got.kind, got.char_out, got.last, got.cursor, got.length);
                    $display("                 ovf=%0d", got.overflow);
                end
                fail_count++;
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (got !== want) begin
                    if (fail_count < 10) begin
                        $display("mismatch: exp kind=%0d char=%02h last=%0d cur=%0d len=%0d",
                                 want.kind, want.char_out, want.last, want.cursor,
                                 want.length);
                        $display("          exp ovf=%0d", want.overflow);
                        $display("          got kind=%0d char=%02h last=%0d cur=%0d len=%0d",
                                 got.kind, got.char_out, got.last, got.cursor,
                                 got.length);
                        $display("          got ovf=%0d", got.overflow);
                    end
                    fail_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ansi_terminal_line_editor_unit_tb NOT OK");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < LINE_LEN; i++) line_buf[i] = 8'h00;
        push      = 1'b0;
        i_char_in = 8'h00;
        i_rst_n   = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_commit();
        test_cursor_moves();
        test_escape_oddities();
        test_full_line_stall();
        test_random_traffic();
        wait_for_results();

        // Anything still owed at this point was never delivered.
        fail_count += pending_results.size();
        if (fail_count == 0) begin
            $display("ansi_terminal_line_editor_unit_tb OK");
        end else begin
            $display("ansi_terminal_line_editor_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/atle_pkg.sv
hdl/atle_fifo.sv
hdl/atle_front.sv
hdl/atle_back.sv
hdl/ansi_terminal_line_editor_unit.sv
verif/ansi_terminal_line_editor_unit_tb.sv
